### rtl/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg: shared types and constants of the wildcard byte pattern scanner
// Item layouts, configuration register map, report codes and queue sizing.
// ----------------------------------------------------------------------------
package wbps_pkg;

    // A pattern byte with this value matches any data byte.
    localparam logic [7:0] WILDCARD_BYTE = 8'h3F;

    // Pattern bytes that the two pattern registers can hold.
    localparam int PAT_BYTES = 16;

    // Configuration port.
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_REG_W  = 5;

    localparam logic [1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [1:0] REG_PATTERN_LEN  = 2'd2;
    localparam logic [1:0] REG_REGION_BASE  = 2'd3;

    localparam logic [LEN_REG_W-1:0] PATTERN_LEN_RESET = 5'd1;

    // Report kinds.
    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    // Entries held between the scanning front and the reporting back.
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       region_end;
    } t_in_item;

    typedef struct packed {
        logic        report_kind;
        logic [31:0] match_address;
        logic [31:0] match_number;
        logic        unique_found;
        logic        final_flag;
    } t_out_item;

    typedef struct packed {
        logic [8*PAT_BYTES-1:0] pattern_bytes;
        logic [LEN_REG_W-1:0]   pattern_length;
        logic [31:0]            region_base;
    } t_scan_cfg;

    typedef struct packed {
        logic        is_match;
        logic        is_last;
        logic [31:0] address;
    } t_scan_entry;

endpackage

### rtl/wbps_front.sv
// ----------------------------------------------------------------------------
// wbps_front: byte window and pattern compare
// Accepts bytes, shifts them into the registered window and then compares the
// window with the pattern and queues a match and/or end-of-region entry.
// ----------------------------------------------------------------------------
module wbps_front #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  wbps_pkg::t_in_item   i_in_item,
    output logic                 o_in_stall,
    input  wbps_pkg::t_scan_cfg  i_cfg,
    input  logic                 i_queue_full,
    output logic                 o_push,
    output wbps_pkg::t_scan_entry o_entry
);

    localparam int WIN   = (MAX_PATTERN < wbps_pkg::PAT_BYTES) ?
                           MAX_PATTERN : wbps_pkg::PAT_BYTES;
    localparam int LEN_W = $clog2(WIN + 1);

    logic [7:0]  r_window [WIN];
    logic [7:0]  n_window [WIN];
    logic [31:0] r_seen;
    logic [31:0] n_seen;
    logic        r_prev_last;
    logic        r_pend;
    logic        r_pend_last;

    logic             accept;
    logic             advance;
    logic [31:0]      seen_base;
    logic [LEN_W-1:0] len_eff;
    logic             window_ok;
    logic             seen_ok;
    logic [31:0]      start_offset;
    logic [7:0]       pat_byte;
    logic [7:0]       win_byte;

    // The compare stage only moves on when the queue can take its entry.
    assign advance    = !(r_pend && i_queue_full);
    assign o_in_stall = !advance;
    assign accept     = i_in_valid && advance;

    // A new region starts from an empty window and a zero byte count.
    assign seen_base = r_prev_last ? 32'd0 : r_seen;
    assign n_seen    = (seen_base == wbps_pkg::COUNT_MAX) ? seen_base : seen_base + 32'd1;

    always_comb begin
        n_window[0] = i_in_item.data_byte;
        for (int k = 1; k < WIN; k++) begin
            n_window[k] = r_prev_last ? 8'd0 : r_window[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= '0;
            r_prev_last <= 1'b0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
        end else begin
            if (advance) begin
                r_pend <= accept;
            end
            if (accept) begin
                r_seen      <= n_seen;
                r_prev_last <= i_in_item.region_end;
                r_pend_last <= i_in_item.region_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_window <= n_window;
        end
    end

    always_comb begin
        if (i_cfg.pattern_length == '0) begin
            len_eff = LEN_W'(1);
        end else if (int'(i_cfg.pattern_length) > WIN) begin
            len_eff = LEN_W'(WIN);
        end else begin
            len_eff = LEN_W'(i_cfg.pattern_length);
        end
    end

    // Pattern byte i lines up with window entry len-1-i (entry 0 is newest).
    always_comb begin
        window_ok = 1'b1;
        pat_byte  = '0;
        win_byte  = '0;
        for (int i = 0; i < WIN; i++) begin
            pat_byte = i_cfg.pattern_bytes[i*8 +: 8];
            win_byte = '0;
            for (int j = 0; j < WIN; j++) begin
                if (i + j + 1 == int'(len_eff)) begin
                    win_byte = r_window[j];
                end
            end
            if (i < int'(len_eff) && pat_byte != wbps_pkg::WILDCARD_BYTE &&
                pat_byte != win_byte) begin
                window_ok = 1'b0;
            end
        end
    end

    assign seen_ok      = r_seen >= 32'(len_eff);
    assign start_offset = r_seen - 32'(len_eff);

    assign o_entry.is_match = window_ok && seen_ok;
    assign o_entry.is_last  = r_pend_last;
    assign o_entry.address  = i_cfg.region_base + start_offset;
    assign o_push = r_pend && advance && ((window_ok && seen_ok) || r_pend_last);

endmodule

### rtl/wbps_queue.sv
// ----------------------------------------------------------------------------
// wbps_queue: short entry queue
// Decouples the compare stage from the report stage so each can stall alone.
// ----------------------------------------------------------------------------
module wbps_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  wbps_pkg::t_scan_entry i_entry,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output wbps_pkg::t_scan_entry o_head
);

    localparam int DEPTH = wbps_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    wbps_pkg::t_scan_entry r_slot [DEPTH];
    logic [PTR_W-1:0]      r_wr_ptr;
    logic [PTR_W-1:0]      r_rd_ptr;
    logic [CNT_W-1:0]      r_count;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("entry pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("entry popped from an empty queue");

endmodule

### rtl/wbps_back.sv
// ----------------------------------------------------------------------------
// wbps_back: match counting and report output
// Takes queued entries, keeps the saturating match count and drives match
// reports and end-of-region verdicts through a registered output.
// ----------------------------------------------------------------------------
module wbps_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  wbps_pkg::t_scan_entry i_head,
    output logic                  o_pop,
    output logic                  o_out_valid,
    output wbps_pkg::t_out_item   o_out_item,
    input  logic                  i_out_stall
);

    logic                r_phase;
    logic                n_phase;
    logic [31:0]         r_count;
    logic [31:0]         n_count;
    logic                r_out_valid;
    logic                n_out_valid;
    wbps_pkg::t_out_item r_out;
    wbps_pkg::t_out_item n_out;

    logic        load_ok;
    logic        work;
    logic        emit_match;
    logic [31:0] count_inc;

    assign load_ok    = !r_out_valid || !i_out_stall;
    assign work       = !i_empty && load_ok;
    assign emit_match = !r_phase && i_head.is_match;
    assign count_inc  = (r_count == wbps_pkg::COUNT_MAX) ? r_count : r_count + 32'd1;

    // An entry carrying both a match and the region end is reported as a match
    // and then a verdict; the phase bit remembers that the match part has gone out.
    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_pop       = 1'b0;
        if (work) begin
            n_out_valid = 1'b1;
            if (emit_match) begin
                n_out.report_kind   = wbps_pkg::KIND_MATCH;
                n_out.match_address = i_head.address;
                n_out.match_number  = count_inc;
                n_out.unique_found  = 1'b0;
                n_out.final_flag    = 1'b0;
                n_count             = count_inc;
                if (i_head.is_last) begin
                    n_phase = 1'b1;
                end else begin
                    o_pop = 1'b1;
                end
            end else begin
                n_out.report_kind   = wbps_pkg::KIND_VERDICT;
                n_out.match_address = '0;
                n_out.match_number  = r_count;
                n_out.unique_found  = r_count == 32'd1;
                n_out.final_flag    = 1'b1;
                n_count             = '0;
                n_phase             = 1'b0;
                o_pop               = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_phase_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (!i_empty && i_head.is_last))
        else $error("verdict pending without an end-of-region entry");

    a_match_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.report_kind == wbps_pkg::KIND_MATCH) |->
        (r_out.match_number != 32'd0 && !r_out.unique_found && !r_out.final_flag))
        else $error("malformed match report");

    a_verdict_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.report_kind == wbps_pkg::KIND_VERDICT) |->
        (r_out.final_flag && r_out.match_address == 32'd0 &&
         r_out.unique_found == (r_out.match_number == 32'd1)))
        else $error("malformed verdict");

endmodule

### rtl/wildcard_byte_pattern_scanner.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner: top level of the byte signature scanner
// Searches a byte stream for a pattern with '?' wildcard bytes.
// ----------------------------------------------------------------------------
// Usage:
// Bytes of a memory region arrive on the input channel (i_in_valid, o_in_stall,
// i_in_item), one item per byte, with region_end set on the last byte. Each
// byte that completes a match of the configured pattern gives a match report
// with its start address and the running match count; the last byte of a
// region also gives a verdict carrying the final count and a flag that is set
// when exactly one match was found.
// Results leave on the output channel (o_out_valid, i_out_stall, o_out_item).
// A report passes through the window register, the entry queue and the output
// register; a byte that yields both a report and a verdict presents them in turn.
// One byte is accepted every cycle while the queue has room; a stalled receiver
// holds the single output register, so it fills the four-entry queue and the
// input then stalls as well.
// The APB-style port writes the pattern, its length and the region base; it
// should be written only while no scan is in flight.
// Reset clears the registers to their defaults and empties the pipeline.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  wbps_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output wbps_pkg::t_out_item               o_out_item,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wbps_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [wbps_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);

    logic [63:0]                      r_pattern_low;
    logic [63:0]                      r_pattern_high;
    logic [wbps_pkg::LEN_REG_W-1:0]   r_pattern_len;
    logic [31:0]                      r_region_base;

    logic                  cfg_write;
    logic [1:0]            reg_index;
    wbps_pkg::t_scan_cfg   scan_cfg;
    logic                  push;
    logic                  pop;
    logic                  queue_full;
    logic                  queue_empty;
    wbps_pkg::t_scan_entry push_entry;
    wbps_pkg::t_scan_entry head_entry;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[4:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low  <= '0;
            r_pattern_high <= '0;
            r_pattern_len  <= wbps_pkg::PATTERN_LEN_RESET;
            r_region_base  <= '0;
        end else if (cfg_write) begin
            case (reg_index)
                wbps_pkg::REG_PATTERN_LOW:  r_pattern_low  <= pwdata;
                wbps_pkg::REG_PATTERN_HIGH: r_pattern_high <= pwdata;
                wbps_pkg::REG_PATTERN_LEN:  r_pattern_len  <= pwdata[wbps_pkg::LEN_REG_W-1:0];
                wbps_pkg::REG_REGION_BASE:  r_region_base  <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            wbps_pkg::REG_PATTERN_LOW:  prdata = r_pattern_low;
            wbps_pkg::REG_PATTERN_HIGH: prdata = r_pattern_high;
            wbps_pkg::REG_PATTERN_LEN:  prdata = {59'd0, r_pattern_len};
            wbps_pkg::REG_REGION_BASE:  prdata = {32'd0, r_region_base};
            default:                    prdata = '0;
        endcase
    end

    assign scan_cfg.pattern_bytes  = {r_pattern_high, r_pattern_low};
    assign scan_cfg.pattern_length = r_pattern_len;
    assign scan_cfg.region_base    = r_region_base;

    wbps_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_item    (i_in_item),
        .o_in_stall   (o_in_stall),
        .i_cfg        (scan_cfg),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    wbps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_empty (queue_empty),
        .o_head  (head_entry)
    );

    wbps_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (queue_empty),
        .i_head      (head_entry),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the wildcard byte pattern scanner
// Streams memory regions through the scanner under several pattern settings
// and flow-control regimes, predicts every match report and verdict, and
// compares each report leaving the block with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SCAN_MAX      = 16;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 80;
    localparam int QUIET_LIMIT   = 3000;
    localparam int SEGMENTS      = 8;
    localparam int SEGMENT_ITEMS = 58;

    // Predicts the reports of the scanner and checks them in order.
    class scan_report_checker;
        logic [8*wbps_pkg::PAT_BYTES-1:0] pattern;
        logic [wbps_pkg::LEN_REG_W-1:0]   length_reg;
        logic [31:0]                      base;
        logic [7:0]                       window [SCAN_MAX];
        logic [31:0]                      bytes_in_region;
        logic [31:0]                      match_count;
        wbps_pkg::t_out_item              pending_reports [$];
        int                               failures;

        function new();
            pattern    = '0;
            length_reg = wbps_pkg::PATTERN_LEN_RESET;
            base       = '0;
            failures   = 0;
            clear_region();
        endfunction

        function void clear_region();
            for (int k = 0; k < SCAN_MAX; k++) begin
                window[k] = 8'h00;
            end
            bytes_in_region = '0;
            match_count     = '0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [63:0] value);
            case (idx)
                wbps_pkg::REG_PATTERN_LOW: begin
                    pattern[63:0] = value;
                end
                wbps_pkg::REG_PATTERN_HIGH: begin
                    pattern[127:64] = value;
                end
                wbps_pkg::REG_PATTERN_LEN: begin
                    length_reg = value[wbps_pkg::LEN_REG_W-1:0];
                end
                default: begin
                    base = value[31:0];
                end
            endcase
        endfunction

        function int active_length();
            int n;
            n = int'(length_reg);
            if (n == 0) n = 1;
            if (n > wbps_pkg::PAT_BYTES) n = wbps_pkg::PAT_BYTES;
            if (n > SCAN_MAX) n = SCAN_MAX;
            return n;
        endfunction

        function logic [7:0] pattern_byte(int i);
            return pattern[8*i +: 8];
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction

        function void take_byte(wbps_pkg::t_in_item it);
            int                  n;
            int                  i;
            bit                  hit;
            wbps_pkg::t_out_item r;
            n = active_length();
            for (i = SCAN_MAX - 1; i > 0; i--) begin
                window[i] = window[i-1];
            end
            window[0] = it.data_byte;
            if (bytes_in_region != wbps_pkg::COUNT_MAX) bytes_in_region++;
            hit = (bytes_in_region >= 32'(n));
            for (i = 0; i < n && hit; i++) begin
                if (pattern_byte(i) != wbps_pkg::WILDCARD_BYTE &&
                    pattern_byte(i) != window[n-1-i]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                if (match_count != wbps_pkg::COUNT_MAX) match_count++;
                r.report_kind   = wbps_pkg::KIND_MATCH;
                r.match_address = base + bytes_in_region - 32'(n);
                r.match_number  = match_count;
                r.unique_found  = 1'b0;
                r.final_flag    = 1'b0;
                pending_reports.push_back(r);
            end
            if (it.region_end) begin
                r.report_kind   = wbps_pkg::KIND_VERDICT;
                r.match_address = '0;
                r.match_number  = match_count;
                r.unique_found  = (match_count == 32'd1);
                r.final_flag    = 1'b1;
                pending_reports.push_back(r);
                clear_region();
            end
        endfunction

        function void check_report(wbps_pkg::t_out_item got);
            wbps_pkg::t_out_item want;
            if (pending_reports.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display({"unexpected report: kind %0d address %h number %h",
                              " unique %0d final %0d"},
                             got.report_kind, got.match_address, got.match_number,
                             got.unique_found, got.final_flag);
                end
                return;
            end
            want = pending_reports.pop_front();
            if (got.report_kind !== want.report_kind
                    || got.match_address !== want.match_address
                    || got.match_number !== want.match_number
                    || got.unique_found !== want.unique_found
                    || got.final_flag !== want.final_flag) begin
                failures++;
                if (failures <= 10) begin
                    $display({"report mismatch: expected kind %0d address %h",
                              " number %h unique %0d final %0d"},
                             want.report_kind, want.match_address, want.match_number,
                             want.unique_found, want.final_flag);
                    $display({"                 got      kind %0d address %h",
                              " number %h unique %0d final %0d"},
                             got.report_kind, got.match_address, got.match_number,
                             got.unique_found, got.final_flag);
                end
            end
        endfunction

        function void close_out();
            if (pending_reports.size() != 0) begin
                if (failures < 10) begin
                    $display("%0d expected reports never arrived", pending_reports.size());
                end
                failures += pending_reports.size();
            end
        endfunction
    endclass

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_in_valid  = 1'b0;
    logic                            o_in_stall;
    wbps_pkg::t_in_item              i_in_item   = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    wbps_pkg::t_out_item             o_out_item;
    logic                            psel        = 1'b0;
    logic                            penable     = 1'b0;
    logic                            pwrite      = 1'b0;
    logic [wbps_pkg::CFG_ADDR_W-1:0] paddr       = '0;
    logic [wbps_pkg::CFG_DATA_W-1:0] pwdata      = '0;
    logic [wbps_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;

    scan_report_checker    sb;
    int                    idle_pct    = 0;
    int                    stall_pct   = 0;
    int                    hold_token  = 0;
    int                    hold_seen   = 0;
    int                    hold_left   = 0;
    int                    quiet_cycles = 0;
    int                    items_sent  = 0;

    wildcard_byte_pattern_scanner #(
        .MAX_PATTERN (SCAN_MAX)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: random stalls, or a long counted hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_report(o_out_item);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    task automatic send_byte(logic [7:0] data, logic last);
        wbps_pkg::t_in_item it;
        it.data_byte  = data;
        it.region_end = last;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_byte(it);
        items_sent++;
    endtask

    // Stops offering items and lets everything in flight come out, including
    // bytes that produce no report and so leave nothing to wait for.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Builds a region from copies of the pattern with random fill, some of the
    // copies broken in one byte, or from pure noise.
    task automatic send_region(int nbytes, bit noisy);
        logic [7:0] region [$];
        logic [7:0] b;
        int         len;
        int         bad;
        len = sb.active_length();
        while (region.size() < nbytes) begin
            if (!noisy && $urandom_range(99) < 30 && region.size() + len <= nbytes) begin
                bad = ($urandom_range(3) == 0) ? int'($urandom_range(len - 1)) : -1;
                for (int i = 0; i < len; i++) begin
                    b = sb.pattern_byte(i);
                    if (b == wbps_pkg::WILDCARD_BYTE) b = 8'($urandom_range(255));
                    if (i == bad) b = b ^ (8'h01 << $urandom_range(7));
                    region.push_back(b);
                end
            end else begin
                region.push_back(8'($urandom_range(255)));
            end
        end
        for (int i = 0; i < nbytes; i++) begin
            send_byte(region[i], i == nbytes - 1);
        end
    endtask

    function automatic logic [63:0] random_pattern_word();
        logic [63:0] w;
        for (int i = 0; i < 8; i++) begin
            w[8*i +: 8] = ($urandom_range(3) == 0) ? wbps_pkg::WILDCARD_BYTE :
                                                     8'($urandom_range(255));
        end
        return w;
    endfunction

    initial begin
        logic [wbps_pkg::LEN_REG_W-1:0] seg_len [SEGMENTS];
        logic [31:0]                    seg_base;
        logic [63:0]                    seg_low;
        int                             len;
        int                             nbytes;
        int                             pick;

        sb = new();
        seg_len = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd8, 5'd5, 5'd2};
        seg_len[6] = 5'($urandom_range(1, 16));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset pattern is a single zero byte.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        settle();

        // Four-byte pattern with a wildcard, base close to the top of memory.
        write_reg(wbps_pkg::REG_PATTERN_LOW, 64'h0000_0000_FF43_3F41);
        write_reg(wbps_pkg::REG_PATTERN_LEN, 64'd4);
        write_reg(wbps_pkg::REG_REGION_BASE, 64'hFFFF_FFFE);
        send_byte(8'h41, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h43, 1'b1);
        send_byte(8'h41, 1'b0);
        send_byte(8'hA7, 1'b0);
        send_byte(8'h43, 1'b0);
        send_byte(8'hFF, 1'b1);
        foreach (seg_len[k]) begin
            if (k < 2) begin
                send_byte(8'h41, 1'b0);
                send_byte(8'($urandom_range(255)), 1'b0);
                send_byte(8'h43, 1'b0);
                send_byte(8'hFF, k == 1);
            end
        end
        settle();

        // A zero length acts as one; the pattern changes in the middle of a region.
        write_reg(wbps_pkg::REG_PATTERN_LEN, 64'd0);
        write_reg(wbps_pkg::REG_PATTERN_LOW, 64'h5A);
        write_reg(wbps_pkg::REG_REGION_BASE, 64'hFFFF_FFFF);
        send_byte(8'h5A, 1'b0);
        settle();
        write_reg(wbps_pkg::REG_PATTERN_LOW, 64'hA5);
        send_byte(8'hA5, 1'b1);
        settle();

        // Every byte matches while the receiver holds off, so the block backs up.
        write_reg(wbps_pkg::REG_PATTERN_LEN, 64'd1);
        write_reg(wbps_pkg::REG_PATTERN_LOW, {56'd0, wbps_pkg::WILDCARD_BYTE});
        write_reg(wbps_pkg::REG_REGION_BASE, 64'd0);
        hold_token++;
        for (int i = 0; i < 24; i++) begin
            send_byte(8'($urandom_range(255)), i == 23);
        end

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            idle_pct  = 0;
            stall_pct = 0;
            settle();
            seg_low  = (seg == 5) ? 64'hFFFF_FFFF_FFFF_FFFF : random_pattern_word();
            seg_base = (seg == 0) ? 32'hFFFF_FFFF : (seg == 1) ? 32'h0 : $urandom;
            write_reg(wbps_pkg::REG_PATTERN_LOW, seg_low);
            write_reg(wbps_pkg::REG_PATTERN_HIGH, random_pattern_word());
            write_reg(wbps_pkg::REG_PATTERN_LEN, 64'(seg_len[seg]));
            write_reg(wbps_pkg::REG_REGION_BASE, 64'(seg_base));
            case (seg % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 62;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 62;
                end
                default: begin
                    idle_pct  = 33;
                    stall_pct = 33;
                end
            endcase
            len = sb.active_length();
            items_sent = 0;
            while (items_sent < SEGMENT_ITEMS) begin
                pick = $urandom_range(9);
                if (pick == 0) begin
                    nbytes = $urandom_range(1, len);
                end else if (pick == 1) begin
                    nbytes = $urandom_range(40, 64);
                end else begin
                    nbytes = $urandom_range(len, 3 * len + 6);
                end
                send_region(nbytes, $urandom_range(6) == 0);
            end
        end

        idle_pct  = 0;
        stall_pct = 0;
        settle();
        sb.close_out();
        if (sb.failures == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
